@@ hdl/spe_pkg.sv @@
// ----------------------------------------------------------------------------
// spe_pkg
// Shared types and constants of the spline path evaluator: controller states,
// read selects, register map and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package spe_pkg;

  // width of the point count register and of segment numbers
  localparam int CNT_W   = 7;
  // width of coordinates and tick values
  localparam int DATA_W  = 32;
  // width of the spline coefficients a, b, d0 (signed)
  localparam int COEF_W  = 37;
  // width of the position accumulator
  localparam int ACC_W   = 64;
  // APB address width and register indexes
  localparam int ADDR_W  = 4;

  typedef enum logic [1:0] {
    REG_POINT_COUNT = 2'd0,
    REG_START_DELAY = 2'd1,
    REG_RUN_LENGTH  = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_t;

  // axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // point memory read selects
  typedef enum logic [2:0] {
    RS_N0   = 3'd0,
    RS_N1   = 3'd1,
    RS_N2   = 3'd2,
    RS_N3   = 3'd3,
    RS_LAST = 3'd4
  } rsel_t;

  // multiply terms of the cubic
  localparam logic [1:0] TERM_CUBE   = 2'd0;
  localparam logic [1:0] TERM_SQUARE = 2'd1;
  localparam logic [1:0] TERM_LINEAR = 2'd2;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_CLASS   = 11'b000_0000_0010,
    S_NUM     = 11'b000_0000_0100,
    S_DIV     = 11'b000_0000_1000,
    S_FETCH   = 11'b000_0001_0000,
    S_COEF    = 11'b000_0010_0000,
    S_MAC     = 11'b000_0100_0000,
    S_ROUND   = 11'b000_1000_0000,
    S_LAST_WT = 11'b001_0000_0000,
    S_EMIT    = 11'b010_0000_0000
  } state_t;

  typedef struct packed {
    logic       load_we;
    logic       eval_cap;
    logic       num_ld;
    logic       div_ld;
    logic       div_step;
    logic       rd_en;
    rsel_t      rd_sel;
    logic       q_cap;
    logic [1:0] q_sel;
    logic       w2_ld;
    logic       w3_ld;
    logic       coef_ld;
    logic [1:0] axis;
    logic       mac_mul;
    logic [1:0] mac_k;
    logic       mac_acc;
    logic       held_ld;
    logic       last_ld;
    logic       out_ld;
    logic       out_fin;
  } cmd_t;

  typedef struct packed {
    logic early;
    logic after;
  } sts_t;

endpackage

`default_nettype wire

@@ hdl/spe_ctrl.sv @@
// ----------------------------------------------------------------------------
// spe_ctrl
// Sequencer of the spline path evaluator: classifies each evaluate beat,
// steps the serial divider, the point fetch, the per-axis multiply-accumulate
// and the result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module spe_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_cmd,
  output logic               in_ready,
  input  wire logic          out_ready,
  output logic               out_valid,
  input  wire spe_pkg::sts_t sts,
  output spe_pkg::cmd_t      cmd
);

  localparam int QW  = spe_pkg::CNT_W + FRAC_BITS;
  localparam int SCW = $clog2(QW);

  spe_pkg::state_t state_r, state_nxt;
  logic [SCW-1:0]  step_r, step_nxt;
  logic [1:0]      axis_r, axis_nxt;
  logic            fin_r, fin_nxt;
  logic            out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    axis_nxt  = axis_r;
    fin_nxt   = fin_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.axis  = axis_r;
    unique case (state_r)
      spe_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd) begin
            cmd.eval_cap = 1'b1;
            state_nxt    = spe_pkg::S_CLASS;
          end else begin
            cmd.load_we = 1'b1;
          end
        end
      end
      spe_pkg::S_CLASS: begin
        cmd.num_ld = 1'b1;
        priority if (sts.early) begin
          fin_nxt   = 1'b0;
          state_nxt = spe_pkg::S_EMIT;
        end else if (sts.after) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = spe_pkg::RS_LAST;
          state_nxt  = spe_pkg::S_LAST_WT;
        end else begin
          state_nxt = spe_pkg::S_NUM;
        end
      end
      spe_pkg::S_NUM: begin
        cmd.div_ld = 1'b1;
        step_nxt   = '0;
        state_nxt  = spe_pkg::S_DIV;
      end
      spe_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == SCW'(QW - 1)) begin
          step_nxt  = '0;
          state_nxt = spe_pkg::S_FETCH;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      spe_pkg::S_FETCH: begin
        // issue four neighbor reads, capture each from the read register on the next step
        if (step_r < SCW'(4)) begin
          cmd.rd_en = 1'b1;
          unique case (step_r[1:0])
            2'd0:    cmd.rd_sel = spe_pkg::RS_N0;
            2'd1:    cmd.rd_sel = spe_pkg::RS_N1;
            2'd2:    cmd.rd_sel = spe_pkg::RS_N2;
            default: cmd.rd_sel = spe_pkg::RS_N3;
          endcase
        end
        if (step_r != '0) begin
          cmd.q_cap = 1'b1;
          cmd.q_sel = 2'(step_r - 1'b1);
        end
        cmd.w2_ld = (step_r == SCW'(0));
        cmd.w3_ld = (step_r == SCW'(1));
        if (step_r == SCW'(4)) begin
          axis_nxt  = spe_pkg::AXIS_X;
          state_nxt = spe_pkg::S_COEF;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      spe_pkg::S_COEF: begin
        cmd.coef_ld = 1'b1;
        step_nxt    = '0;
        state_nxt   = spe_pkg::S_MAC;
      end
      spe_pkg::S_MAC: begin
        // multiply one term, add the previous product
        if (step_r < SCW'(3)) begin
          cmd.mac_mul = 1'b1;
          cmd.mac_k   = step_r[1:0];
        end
        cmd.mac_acc = (step_r != '0);
        if (step_r == SCW'(3)) begin
          state_nxt = spe_pkg::S_ROUND;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      spe_pkg::S_ROUND: begin
        cmd.held_ld = 1'b1;
        if (axis_r == spe_pkg::AXIS_Z) begin
          fin_nxt   = 1'b0;
          state_nxt = spe_pkg::S_EMIT;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = spe_pkg::S_COEF;
        end
      end
      spe_pkg::S_LAST_WT: begin
        cmd.last_ld = 1'b1;
        fin_nxt     = 1'b1;
        state_nxt   = spe_pkg::S_EMIT;
      end
      spe_pkg::S_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_ld  = 1'b1;
          cmd.out_fin = fin_r;
          state_nxt   = spe_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = spe_pkg::S_IDLE;
      end
    endcase
  end

  // output beat valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spe_pkg::S_IDLE;
      step_r      <= '0;
      axis_r      <= spe_pkg::AXIS_X;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      axis_r      <= axis_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/spe_dp.sv @@
// ----------------------------------------------------------------------------
// spe_dp
// Datapath of the spline path evaluator: point memory, time classification,
// restoring divider, weight powers, shared coefficient multiplier, rounding,
// held position and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module spe_dp #(
  parameter int MAX_POINTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire spe_pkg::cmd_t        cmd,
  output spe_pkg::sts_t             sts,
  input  wire logic [6:0]           point_count,
  input  wire logic [31:0]          start_delay,
  input  wire logic [31:0]          run_length,
  input  wire logic [5:0]           in_point_index,
  input  wire logic signed [31:0]   in_coord_x,
  input  wire logic signed [31:0]   in_coord_y,
  input  wire logic signed [31:0]   in_coord_z,
  input  wire logic [31:0]          in_elapsed_time,
  output logic signed [31:0]        out_pos_x,
  output logic signed [31:0]        out_pos_y,
  output logic signed [31:0]        out_pos_z,
  output logic                      out_finished
);

  localparam int CW  = spe_pkg::CNT_W;
  localparam int DW  = spe_pkg::DATA_W;
  localparam int FW  = spe_pkg::COEF_W;
  localparam int AW2 = spe_pkg::ACC_W;
  localparam int QW  = CW + FRAC_BITS;
  localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int WA  = (AW > CW) ? AW : CW;
  localparam int WA1 = WA + 1;
  localparam int PW  = FW + FRAC_BITS + 1;

  // point memory, x in the low word
  logic [3*DW-1:0]      mem [MAX_POINTS];
  logic [3*DW-1:0]      rd_data_r;
  logic [3*DW-1:0]      q_r [4];

  logic [DW-1:0]        diff_r;
  logic [CW-1:0]        cnt_r;
  logic [CW-1:0]        cnt_c;
  logic [DW-1:0]        dur_c;
  logic                 early_r;
  logic                 after_r;
  logic [CW+DW-1:0]     num_r;
  logic [DW-1:0]        rem_r;
  logic [QW-1:0]        quo_r;
  logic [DW:0]          div_t;
  logic                 div_ge;
  logic [FRAC_BITS-1:0] w_c;
  logic [FRAC_BITS-1:0] w2_r;
  logic [FRAC_BITS-1:0] w3_r;
  logic [2*FRAC_BITS-1:0] wsq;
  logic [2*FRAC_BITS-1:0] wcb;

  logic [CW-1:0]        seg_c, s_c, cm1_c, i0_c, i2_c, i3_c, ra7_c;
  logic [CW:0]          s1_c, s2_c;
  logic [WA-1:0]        ra_w, wa_w;
  logic                 wr_ok;

  logic signed [DW-1:0] p0_c, p1_c, p2_c, p3_c;
  logic signed [FW-1:0] d0_c, d1_c, e_c;
  logic signed [FW-1:0] a_r, b_r, d0_r;
  logic signed [FW-1:0] mc_c;
  logic [FRAC_BITS-1:0] mw_c;
  logic signed [FRAC_BITS:0] mws_c;
  logic signed [PW-1:0] prod_r;
  logic signed [AW2-1:0] acc_r;
  logic signed [AW2-1:0] shr_c;
  logic signed [DW-1:0] rnd_c;

  logic signed [DW-1:0] held_x_r, held_y_r, held_z_r;
  logic signed [DW-1:0] out_x_r, out_y_r, out_z_r;
  logic                 out_fin_r;

  assign sts.early = early_r;
  assign sts.after = after_r;

  // clamp configuration
  always_comb begin
    priority if (point_count == '0) begin
      cnt_c = CW'(1);
    end else if (32'(point_count) > MAX_POINTS) begin
      cnt_c = CW'(MAX_POINTS);
    end else begin
      cnt_c = point_count;
    end
    dur_c = (run_length == '0) ? DW'(1) : run_length;
  end

  // write and read the point memory
  assign wa_w  = WA'(in_point_index);
  assign wr_ok = ({1'b0, wa_w} < WA1'(MAX_POINTS));

  always_ff @(posedge clk) begin
    if (cmd.load_we && wr_ok) begin
      mem[wa_w[AW-1:0]] <= {in_coord_z, in_coord_y, in_coord_x};
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[ra_w[AW-1:0]];
    end
  end

  // neighbor indices, clamped at both ends
  always_comb begin
    seg_c = quo_r[QW-1:FRAC_BITS];
    w_c   = quo_r[FRAC_BITS-1:0];
    cm1_c = cnt_r - 1'b1;
    s_c   = (seg_c > cm1_c) ? cm1_c : seg_c;
    i0_c  = (s_c == '0) ? s_c : s_c - 1'b1;
    s1_c  = {1'b0, s_c} + 1'b1;
    s2_c  = {1'b0, s_c} + 2'd2;
    i2_c  = (s1_c < {1'b0, cnt_r}) ? s1_c[CW-1:0] : s_c;
    i3_c  = (s2_c < {1'b0, cnt_r}) ? s2_c[CW-1:0] : s_c;
    unique case (cmd.rd_sel)
      spe_pkg::RS_N0:   ra7_c = i0_c;
      spe_pkg::RS_N1:   ra7_c = s_c;
      spe_pkg::RS_N2:   ra7_c = i2_c;
      spe_pkg::RS_N3:   ra7_c = i3_c;
      spe_pkg::RS_LAST: ra7_c = cm1_c;
      default:          ra7_c = cm1_c;
    endcase
    ra_w = WA'(ra7_c);
  end

  // classify the evaluate beat and form the dividend
  always_ff @(posedge clk) begin
    if (cmd.eval_cap) begin
      diff_r  <= in_elapsed_time - start_delay;
      cnt_r   <= cnt_c;
      early_r <= (in_elapsed_time < start_delay);
      after_r <= ({1'b0, in_elapsed_time} >= ({1'b0, start_delay} + {1'b0, dur_c}));
    end
    if (cmd.num_ld) begin
      num_r <= (CW + DW)'(cnt_r - 1'b1) * (CW + DW)'(diff_r);
    end
  end

  // restoring divider: one quotient bit a step
  assign div_t  = {rem_r, quo_r[QW-1]};
  assign div_ge = (div_t >= {1'b0, dur_c});

  always_ff @(posedge clk) begin
    if (cmd.div_ld) begin
      rem_r <= num_r[CW+DW-1:CW];
      quo_r <= {num_r[CW-1:0], {FRAC_BITS{1'b0}}};
    end else if (cmd.div_step) begin
      rem_r <= div_ge ? DW'(div_t - {1'b0, dur_c}) : div_t[DW-1:0];
      quo_r <= {quo_r[QW-2:0], div_ge};
    end
  end

  // weight powers
  assign wsq = (2*FRAC_BITS)'(w_c) * (2*FRAC_BITS)'(w_c);
  assign wcb = (2*FRAC_BITS)'(w2_r) * (2*FRAC_BITS)'(w_c);

  always_ff @(posedge clk) begin
    if (cmd.w2_ld) begin
      w2_r <= wsq[2*FRAC_BITS-1:FRAC_BITS];
    end
    if (cmd.w3_ld) begin
      w3_r <= wcb[2*FRAC_BITS-1:FRAC_BITS];
    end
    if (cmd.q_cap) begin
      q_r[cmd.q_sel] <= rd_data_r;
    end
  end

  // select one axis of the four neighbors
  always_comb begin
    unique case (cmd.axis)
      spe_pkg::AXIS_X: begin
        p0_c = q_r[0][DW-1:0];      p1_c = q_r[1][DW-1:0];
        p2_c = q_r[2][DW-1:0];      p3_c = q_r[3][DW-1:0];
      end
      spe_pkg::AXIS_Y: begin
        p0_c = q_r[0][2*DW-1:DW];   p1_c = q_r[1][2*DW-1:DW];
        p2_c = q_r[2][2*DW-1:DW];   p3_c = q_r[3][2*DW-1:DW];
      end
      default: begin
        p0_c = q_r[0][3*DW-1:2*DW]; p1_c = q_r[1][3*DW-1:2*DW];
        p2_c = q_r[2][3*DW-1:2*DW]; p3_c = q_r[3][3*DW-1:2*DW];
      end
    endcase
    d0_c = FW'(p2_c) - FW'(p0_c);
    d1_c = FW'(p3_c) - FW'(p1_c);
    e_c  = FW'(p1_c) - FW'(p2_c);
  end

  // multiplier operands
  always_comb begin
    unique case (cmd.mac_k)
      spe_pkg::TERM_CUBE:   begin mc_c = a_r;  mw_c = w3_r; end
      spe_pkg::TERM_SQUARE: begin mc_c = b_r;  mw_c = w2_r; end
      default:              begin mc_c = d0_r; mw_c = w_c;  end
    endcase
    mws_c = $signed({1'b0, mw_c});
  end

  // coefficients, products and the doubled cubic sum
  always_ff @(posedge clk) begin
    if (cmd.coef_ld) begin
      a_r   <= (e_c <<< 2) + d0_c + d1_c;
      b_r   <= -((e_c <<< 2) + (e_c <<< 1)) - (d0_c <<< 1) - d1_c;
      d0_r  <= d0_c;
      acc_r <= (AW2'(p1_c) <<< (FRAC_BITS + 1)) + (AW2'(1) <<< FRAC_BITS);
    end else if (cmd.mac_acc) begin
      acc_r <= acc_r + AW2'(prod_r);
    end
    if (cmd.mac_mul) begin
      prod_r <= mc_c * mws_c;
    end
  end

  // floor shift and saturate
  always_comb begin
    shr_c = acc_r >>> (FRAC_BITS + 1);
    priority if (shr_c > AW2'(64'sd2147483647)) begin
      rnd_c = 32'sh7fffffff;
    end else if (shr_c < -AW2'(64'sd2147483648)) begin
      rnd_c = 32'sh80000000;
    end else begin
      rnd_c = shr_c[DW-1:0];
    end
  end

  // held position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_x_r <= '0;
      held_y_r <= '0;
      held_z_r <= '0;
    end else if (cmd.last_ld) begin
      held_x_r <= rd_data_r[DW-1:0];
      held_y_r <= rd_data_r[2*DW-1:DW];
      held_z_r <= rd_data_r[3*DW-1:2*DW];
    end else if (cmd.held_ld) begin
      unique case (cmd.axis)
        spe_pkg::AXIS_X: held_x_r <= rnd_c;
        spe_pkg::AXIS_Y: held_y_r <= rnd_c;
        default:         held_z_r <= rnd_c;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_x_r   <= held_x_r;
      out_y_r   <= held_y_r;
      out_z_r   <= held_z_r;
      out_fin_r <= cmd.out_fin;
    end
  end

  assign out_pos_x    = out_x_r;
  assign out_pos_y    = out_y_r;
  assign out_pos_z    = out_z_r;
  assign out_finished = out_fin_r;

endmodule

`default_nettype wire

@@ hdl/spline_path_evaluator_unit.sv @@
// ----------------------------------------------------------------------------
// spline_path_evaluator_unit
// Catmull-Rom path evaluator over stored control points, three axes, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): in_cmd 0 writes control point
//   in_point_index and gives no result; in_cmd 1 evaluates the path at
//   in_elapsed_time and gives one result beat on the out_ channel.
//   A load beat keeps the block idle; the next beat is accepted right after.
//   An evaluate beat before the start delay goes straight to its result, one
//   at or after the end of the run first reads the last point, and one inside
//   the run takes longest: the 23-step serial
//   divider and the three-axis pass through one shared multiplier set it.
//   The next beat is accepted the cycle after the result is registered.
//   Registers (APB, 32-bit): point_count at 0x0, start_delay at 0x4,
//   run_length at 0x8; write them only while the block is idle.
//   Reset clears the registers to count 1, delay 0, run length 1, zeroes the
//   held position and empties the output register; point memory is not
//   cleared and must be loaded before use.
//   A result waits in the output register while out_ready is low; a new beat
//   is still accepted, and its result waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module spline_path_evaluator_unit #(
  parameter int MAX_POINTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_cmd,
  input  wire logic [5:0]                          in_point_index,
  input  wire logic signed [31:0]                  in_coord_x,
  input  wire logic signed [31:0]                  in_coord_y,
  input  wire logic signed [31:0]                  in_coord_z,
  input  wire logic [31:0]                         in_elapsed_time,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [31:0]                       out_pos_x,
  output logic signed [31:0]                       out_pos_y,
  output logic signed [31:0]                       out_pos_z,
  output logic                                     out_finished,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [spe_pkg::ADDR_W-1:0]          paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);

  logic [6:0]        point_count_r;
  logic [31:0]       start_delay_r;
  logic [31:0]       run_length_r;
  logic              cfg_we;
  spe_pkg::reg_idx_t cfg_idx;
  spe_pkg::cmd_t     cmd;
  spe_pkg::sts_t     sts;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = spe_pkg::reg_idx_t'(paddr[3:2]);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= 7'd1;
      start_delay_r <= '0;
      run_length_r  <= 32'd1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        spe_pkg::REG_POINT_COUNT: point_count_r <= pwdata[6:0];
        spe_pkg::REG_START_DELAY: start_delay_r <= pwdata;
        spe_pkg::REG_RUN_LENGTH:  run_length_r  <= pwdata;
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_idx)
      spe_pkg::REG_POINT_COUNT: prdata = {25'd0, point_count_r};
      spe_pkg::REG_START_DELAY: prdata = start_delay_r;
      spe_pkg::REG_RUN_LENGTH:  prdata = run_length_r;
      default:                  prdata = '0;
    endcase
  end

  spe_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  spe_dp #(
    .MAX_POINTS (MAX_POINTS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .point_count     (point_count_r),
    .start_delay     (start_delay_r),
    .run_length      (run_length_r),
    .in_point_index  (in_point_index),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_coord_z      (in_coord_z),
    .in_elapsed_time (in_elapsed_time),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_pos_z       (out_pos_z),
    .out_finished    (out_finished)
  );

  // an evaluate beat closes the input until its result is handed off
  a_eval_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_cmd) |=> !in_ready)
    else $error("input still open after evaluate beat");

  // a load beat never stalls the input
  a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_cmd) |=> in_ready)
    else $error("input closed after load beat");

  // a new result only appears from the handoff state
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

endmodule

`default_nettype wire
